@@ rtl/isf_pkg.sv @@
// ----------------------------------------------------------------------------
// isf_pkg: shared types and constants of the IMU sync packet framer
// Packet geometry, event codes and the CRC-16/CCITT-FALSE byte step.
// ----------------------------------------------------------------------------
package isf_pkg;

  // packet geometry
  localparam int PKT_LEN   = 54;
  localparam int CRC_SPAN  = 52;
  localparam int PKT_BITS  = CRC_SPAN * 8;
  localparam int CNT_W     = $clog2(PKT_LEN);

  // field widths
  localparam int ACT_W     = 2;
  localparam int TIME_W    = 64;
  localparam int WORD_W    = 32;
  localparam int BYTE_W    = 8;

  // crc and header constants
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_TOP    = 16'h8000;
  localparam logic [15:0] PKT_HEADER = 16'hA5A5;

  // event codes
  typedef enum logic [ACT_W-1:0] {
    ACT_TRIGGER = 2'd0,
    ACT_STROBE  = 2'd1,
    ACT_IMU     = 2'd2
  } act_t;

  // packet body, byte 0 in the low bits
  typedef logic [PKT_BITS-1:0] pkt_t;

  // serializer status seen by the top level
  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

  // one byte through the msb-first crc
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/isf_stream_if.sv @@
// ----------------------------------------------------------------------------
// isf_stream_if: valid/ready channels of the IMU sync packet framer
// Event input channel and packet byte output channel.
// ----------------------------------------------------------------------------
interface isf_in_if import isf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [TIME_W-1:0]   time_us;
  logic [WORD_W-1:0]   acc_x;
  logic [WORD_W-1:0]   acc_y;
  logic [WORD_W-1:0]   acc_z;
  logic [WORD_W-1:0]   gyro_x;
  logic [WORD_W-1:0]   gyro_y;
  logic [WORD_W-1:0]   gyro_z;

  modport source (output valid, action, time_us, acc_x, acc_y, acc_z,
                  gyro_x, gyro_y, gyro_z, input ready);
  modport sink   (input valid, action, time_us, acc_x, acc_y, acc_z,
                  gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface isf_out_if import isf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

@@ rtl/isf_capture.sv @@
// ----------------------------------------------------------------------------
// isf_capture: event tracking and packet snapshot
// Keeps frame count, marks and strobe time; builds a packet body per sample.
// ----------------------------------------------------------------------------
module isf_capture import isf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  isf_in_if.sink     in_ch,
  output logic       pend_valid,
  output pkt_t       pend_pkt,
  input  logic       take
);

  logic [WORD_W-1:0] frame_count_r, frame_count_nxt;
  logic              trig_r, trig_nxt;
  logic              strobe_r, strobe_nxt;
  logic [TIME_W-1:0] stime_r, stime_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  pkt_t              pkt_r, pkt_nxt;
  logic              acc;
  logic [TIME_W-1:0] stime_eff;

  // one pending packet slot, free again in the cycle the serializer takes it
  assign in_ch.ready = !pend_valid_r || take;
  assign acc         = in_ch.valid && in_ch.ready;
  assign stime_eff   = strobe_r ? stime_r : '0;

  // event decode and packet build
  always_comb begin
    frame_count_nxt = frame_count_r;
    trig_nxt        = trig_r;
    strobe_nxt      = strobe_r;
    stime_nxt       = stime_r;
    pkt_nxt         = pkt_r;
    pend_valid_nxt  = pend_valid_r && !take;
    if (acc) begin
      unique case (in_ch.action)
        ACT_TRIGGER: begin
          frame_count_nxt = frame_count_r + WORD_W'(1);
          trig_nxt        = 1'b1;
        end
        ACT_STROBE: begin
          stime_nxt  = in_ch.time_us;
          strobe_nxt = 1'b1;
        end
        ACT_IMU: begin
          pkt_nxt = {stime_eff, 7'd0, strobe_r, 7'd0, trig_r,
                     in_ch.gyro_z, in_ch.gyro_y, in_ch.gyro_x,
                     in_ch.acc_z, in_ch.acc_y, in_ch.acc_x,
                     {(TIME_W-WORD_W){1'b0}}, frame_count_r,
                     in_ch.time_us, PKT_HEADER};
          pend_valid_nxt = 1'b1;
          trig_nxt       = 1'b0;
          strobe_nxt     = 1'b0;
        end
        default: begin
          // unused code: ignored
        end
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      trig_r        <= 1'b0;
      strobe_r      <= 1'b0;
      stime_r       <= '0;
      pend_valid_r  <= 1'b0;
    end else begin
      frame_count_r <= frame_count_nxt;
      trig_r        <= trig_nxt;
      strobe_r      <= strobe_nxt;
      stime_r       <= stime_nxt;
      pend_valid_r  <= pend_valid_nxt;
    end
  end

  // packet body, no reset
  always_ff @(posedge clk) begin
    pkt_r <= pkt_nxt;
  end

  assign pend_valid = pend_valid_r;
  assign pend_pkt   = pkt_r;

endmodule

@@ rtl/isf_serializer.sv @@
// ----------------------------------------------------------------------------
// isf_serializer: packet byte shifter with running crc
// Sends 52 body bytes, then the crc low and high byte, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module isf_serializer import isf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pend_valid,
  input  pkt_t       pend_pkt,
  output logic       take,
  output ser_stat_t  stat,
  isf_out_if.source  out_ch
);

  localparam logic [CNT_W-1:0] SPAN_CNT = CNT_W'(CRC_SPAN);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PKT_LEN - 1);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  pkt_t              sh_r, sh_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              adv, emit, done;
  logic [BYTE_W-1:0] cur_byte;

  // output register free or being drained
  assign adv  = !out_valid_r || out_ch.ready;
  assign emit = busy_r && adv;
  assign done = emit && (cnt_r == LAST_CNT);
  assign take = pend_valid && (!busy_r || done);

  // byte select: body, then crc low, then crc high
  always_comb begin
    if (cnt_r < SPAN_CNT) begin
      cur_byte = sh_r[BYTE_W-1:0];
    end else if (cnt_r == SPAN_CNT) begin
      cur_byte = crc_r[7:0];
    end else begin
      cur_byte = crc_r[15:8];
    end
  end

  // shifter, crc and output stage
  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    sh_nxt        = sh_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = (cnt_r == LAST_CNT);
      cnt_nxt       = cnt_r + CNT_W'(1);
      sh_nxt        = sh_r >> BYTE_W;
      if (cnt_r < SPAN_CNT) begin
        crc_nxt = crc_byte(crc_r, sh_r[BYTE_W-1:0]);
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = pend_pkt;
      crc_nxt  = CRC_INIT;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;
  assign stat.busy        = busy_r;
  assign stat.done        = done;

endmodule

@@ rtl/imu_sync_packet_framer.sv @@
// Trigger and strobe events produce no output.
// An IMU sample is registered in the snapshot slot, loaded into the single
// byte serializer and sent one byte per cycle while the output is ready.
// One packet waits in a snapshot slot while the previous one is sent.
// Synchronous active-low reset clears frame count, marks and strobe time.
// ----------------------------------------------------------------------------
// imu_sync_packet_framer: camera/IMU event tracker and packet framer
// Frames each IMU sample as a 54-byte packet protected by CRC-16/CCITT-FALSE.
// ----------------------------------------------------------------------------
module imu_sync_packet_framer import isf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  isf_in_if.sink    in_ch,
  isf_out_if.source out_ch
);

  logic      pend_valid;
  pkt_t      pend_pkt;
  logic      take;
  ser_stat_t stat;

  // event tracking and packet snapshot
  isf_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .pend_valid (pend_valid),
    .pend_pkt   (pend_pkt),
    .take       (take)
  );

  // byte serializer with crc
  isf_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .pend_valid (pend_valid),
    .pend_pkt   (pend_pkt),
    .take       (take),
    .stat       (stat),
    .out_ch     (out_ch)
  );

`ifndef SYNTH
  // a waiting packet stays until the serializer takes it
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid && !take |=> pend_valid)
    else $error("pending packet lost");

  // the serializer takes only a waiting packet
  a_take_pend: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> pend_valid)
    else $error("serializer took an empty slot");

  // a taken packet starts sending
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> stat.busy)
    else $error("serializer idle after load");

  // packet end only while sending
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> stat.busy)
    else $error("packet end while idle");
`endif

endmodule

@@ dv/tb_imu_sync_packet_framer.sv @@
// ----------------------------------------------------------------------------
// tb_imu_sync_packet_framer: self-checking bench of the IMU sync packet framer
// Sends trigger, strobe, unused and IMU sample events with bursty timing,
// frames the packets it expects from its own copy of the marks and frame
// count, and checks every packet byte and the last-byte flag.
// ----------------------------------------------------------------------------
module tb_imu_sync_packet_framer;
  import isf_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int N_ITEMS        = 180;

  // content styles of generated items
  localparam int FILL_ZERO = 0;
  localparam int FILL_ONES = 1;
  localparam int FILL_RAND = 2;

  typedef enum int {RDY_OPEN, RDY_RANDOM, RDY_BURSTY} rdy_mode_t;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] time_us;
    logic [WORD_W-1:0] acc_x;
    logic [WORD_W-1:0] acc_y;
    logic [WORD_W-1:0] acc_z;
    logic [WORD_W-1:0] gyro_x;
    logic [WORD_W-1:0] gyro_y;
    logic [WORD_W-1:0] gyro_z;
  } imu_ev_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } pkt_byte_t;

  logic clk;
  logic rst_n;

  isf_in_if  in_ch();
  isf_out_if out_ch();

  imu_sync_packet_framer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // event items waiting to be sent, packet bytes waiting to arrive
  imu_ev_t   ev_pend_q[$];
  pkt_byte_t pkt_byte_q[$];

  // tracked framer state
  logic [31:0]     frame_cnt;
  logic            trig_pend;
  logic            strb_pend;
  logic [TIME_W-1:0] strb_time;

  int n_items;
  int in_acc_cnt;
  int mism_cnt;
  int idle_cnt;

  // sender and receiver pacing
  int        burst_left;
  int        gap_left;
  int        mode_left;
  int        stall_left;
  rdy_mode_t rdy_mode;
  imu_ev_t   drv_ev;
  imu_ev_t   mon_ev;
  pkt_byte_t want;

  // clock and reset level from time zero
  initial begin
    clk   = 1'b0;
    rst_n = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // raw words lean toward corner values now and then
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return TIME_W'($urandom_range(0, 1000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic imu_ev_t mk_ev(input logic [ACT_W-1:0] act,
                                    input logic [TIME_W-1:0] t,
                                    input int fill);
    imu_ev_t ev;
    ev.action  = act;
    ev.time_us = t;
    if (fill == FILL_RAND) begin
      ev.acc_x  = rand_word();
      ev.acc_y  = rand_word();
      ev.acc_z  = rand_word();
      ev.gyro_x = rand_word();
      ev.gyro_y = rand_word();
      ev.gyro_z = rand_word();
    end else begin
      ev.acc_x  = (fill == FILL_ONES) ? '1 : '0;
      ev.acc_y  = ev.acc_x;
      ev.acc_z  = ev.acc_x;
      ev.gyro_x = ev.acc_x;
      ev.gyro_y = ev.acc_x;
      ev.gyro_z = ev.acc_x;
    end
    return ev;
  endfunction

  function automatic void push_ev(input logic [ACT_W-1:0] act,
                                  input logic [TIME_W-1:0] t, input int fill);
    ev_pend_q.push_back(mk_ev(act, t, fill));
  endfunction

  // build the expected 54-byte packet of one IMU sample
  function automatic void frame_imu_sample(input imu_ev_t ev);
    logic [7:0]        pkt[PKT_LEN];
    logic [WORD_W-1:0] words[6];
    logic [63:0]       cnt64;
    logic [63:0]       stime;
    logic [15:0]       crc;
    logic              fb;
    pkt_byte_t         pb;
    words = '{ev.acc_x, ev.acc_y, ev.acc_z, ev.gyro_x, ev.gyro_y, ev.gyro_z};
    cnt64 = {32'h0, frame_cnt};
    stime = strb_pend ? strb_time : '0;
    pkt[0] = PKT_HEADER[7:0];
    pkt[1] = PKT_HEADER[15:8];
    for (int i = 0; i < 8; i++) begin
      pkt[2 + i]  = ev.time_us[8*i +: 8];
      pkt[10 + i] = cnt64[8*i +: 8];
      pkt[44 + i] = stime[8*i +: 8];
    end
    for (int w = 0; w < 6; w++) begin
      for (int i = 0; i < 4; i++) begin
        pkt[18 + 4*w + i] = words[w][8*i +: 8];
      end
    end
    pkt[42] = {7'h0, trig_pend};
    pkt[43] = {7'h0, strb_pend};
    // crc shifted one bit at a time, msb first
    crc = CRC_INIT;
    for (int i = 0; i < CRC_SPAN; i++) begin
      for (int b = 7; b >= 0; b--) begin
        fb  = crc[15] ^ pkt[i][b];
        crc = {crc[14:0], 1'b0};
        if (fb) begin
          crc = crc ^ CRC_POLY;
        end
      end
    end
    pkt[CRC_SPAN]     = crc[7:0];
    pkt[CRC_SPAN + 1] = crc[15:8];
    for (int i = 0; i < PKT_LEN; i++) begin
      pb.data = pkt[i];
      pb.last = (i == PKT_LEN - 1);
      pkt_byte_q.push_back(pb);
    end
  endfunction

  // advance tracked state on one accepted item
  function automatic void track_event(input imu_ev_t ev);
    if (ev.action == ACT_TRIGGER) begin
      frame_cnt = frame_cnt + 32'd1;
      trig_pend = 1'b1;
    end else if (ev.action == ACT_STROBE) begin
      strb_time = ev.time_us;
      strb_pend = 1'b1;
    end else if (ev.action == ACT_IMU) begin
      frame_imu_sample(ev);
      trig_pend = 1'b0;
      strb_pend = 1'b0;
    end
  endfunction

  // sender: bursts of items with random gaps, some long gapless stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (ev_pend_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        drv_ev = ev_pend_q.pop_front();
        in_ch.action  <= drv_ev.action;
        in_ch.time_us <= drv_ev.time_us;
        in_ch.acc_x   <= drv_ev.acc_x;
        in_ch.acc_y   <= drv_ev.acc_y;
        in_ch.acc_z   <= drv_ev.acc_z;
        in_ch.gyro_x  <= drv_ev.gyro_x;
        in_ch.gyro_y  <= drv_ev.gyro_y;
        in_ch.gyro_z  <= drv_ev.gyro_z;
        in_ch.valid   <= 1'b1;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(30, 60);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left   = $urandom_range(1, 12);
        end
      end
    end
  end

  // receiver: open, random and bursty stall modes in turn
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  = rdy_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(40, 200);
      end else begin
        mode_left = mode_left - 1;
      end
      case (rdy_mode)
        RDY_OPEN: begin
          out_ch.ready <= 1'b1;
        end
        RDY_RANDOM: begin
          out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // monitor: track accepted events, check accepted bytes, count idle cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        mon_ev.action  = in_ch.action;
        mon_ev.time_us = in_ch.time_us;
        mon_ev.acc_x   = in_ch.acc_x;
        mon_ev.acc_y   = in_ch.acc_y;
        mon_ev.acc_z   = in_ch.acc_z;
        mon_ev.gyro_x  = in_ch.gyro_x;
        mon_ev.gyro_y  = in_ch.gyro_y;
        mon_ev.gyro_z  = in_ch.gyro_z;
        track_event(mon_ev);
        in_acc_cnt = in_acc_cnt + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pkt_byte_q.size() == 0) begin
          if (mism_cnt < 10) begin
            $display("unexpected byte: data %h last %b", out_ch.out_byte,
                     out_ch.last_byte);
          end
          mism_cnt = mism_cnt + 1;
        end else begin
          want = pkt_byte_q.pop_front();
          if (want.data !== out_ch.out_byte || want.last !== out_ch.last_byte) begin
            if (mism_cnt < 10) begin
              $display("byte mismatch: expected data %h last %b, got data %h last %b",
                       want.data, want.last, out_ch.out_byte, out_ch.last_byte);
            end
            mism_cnt = mism_cnt + 1;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt = idle_cnt + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    frame_cnt  = '0;
    trig_pend  = 1'b0;
    strb_pend  = 1'b0;
    strb_time  = '0;
    in_acc_cnt = 0;
    mism_cnt   = 0;
    idle_cnt   = 0;
    burst_left = 1;
    gap_left   = 0;
    mode_left  = 0;
    stall_left = 0;
    rdy_mode   = RDY_OPEN;

    // field extremes with no marks pending
    push_ev(ACT_IMU, '0, FILL_ZERO);
    push_ev(ACT_IMU, '1, FILL_ONES);
    // trigger flag alone
    push_ev(ACT_TRIGGER, rand_time(), FILL_RAND);
    push_ev(ACT_IMU, rand_time(), FILL_RAND);
    // strobe flag with all-ones strobe time
    push_ev(ACT_STROBE, '1, FILL_ONES);
    push_ev(ACT_IMU, rand_time(), FILL_RAND);
    // later strobe edge overwrites the earlier time
    push_ev(ACT_STROBE, rand_time(), FILL_RAND);
    push_ev(ACT_STROBE, rand_time(), FILL_RAND);
    push_ev(ACT_IMU, rand_time(), FILL_RAND);
    // two frames counted, strobe at time zero still flagged
    push_ev(ACT_TRIGGER, '0, FILL_ZERO);
    push_ev(ACT_TRIGGER, '1, FILL_ONES);
    push_ev(ACT_STROBE, '0, FILL_ZERO);
    push_ev(ACT_IMU, rand_time(), FILL_RAND);
    // unused code is ignored
    push_ev(ACT_UNUSED, '1, FILL_ONES);
    push_ev(ACT_IMU, rand_time(), FILL_RAND);
    push_ev(ACT_STROBE, rand_time(), FILL_RAND);
    push_ev(ACT_UNUSED, rand_time(), FILL_RAND);
    push_ev(ACT_TRIGGER, rand_time(), FILL_RAND);
    push_ev(ACT_IMU, rand_time(), FILL_RAND);
    // marks cleared by the previous packet
    push_ev(ACT_IMU, rand_time(), FILL_RAND);

    // mostly frame-shaped sequences, the rest loose events of any code
    while (ev_pend_q.size() < N_ITEMS) begin
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 9) < 7) begin
          push_ev(ACT_TRIGGER, rand_time(), FILL_RAND);
        end
        if ($urandom_range(0, 9) < 6) begin
          repeat ($urandom_range(1, 2)) push_ev(ACT_STROBE, rand_time(), FILL_RAND);
        end
        repeat ($urandom_range(1, 3)) push_ev(ACT_IMU, rand_time(), FILL_RAND);
      end else begin
        push_ev(ACT_W'($urandom_range(0, 3)), rand_time(), FILL_RAND);
      end
    end
    n_items = ev_pend_q.size();

    while (!(in_acc_cnt == n_items && pkt_byte_q.size() == 0) &&
           idle_cnt < WATCHDOG_LIMIT) begin
      @(negedge clk);
    end
    if (idle_cnt < WATCHDOG_LIMIT) begin
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("imu_sync_packet_framer: mismatch");
    end else if (mism_cnt == 0 && pkt_byte_q.size() == 0) begin
      $display("imu_sync_packet_framer: match");
    end else begin
      $display("imu_sync_packet_framer: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/isf_pkg.sv
rtl/isf_stream_if.sv
rtl/isf_capture.sv
rtl/isf_serializer.sv
rtl/imu_sync_packet_framer.sv
dv/tb_imu_sync_packet_framer.sv
